[sv/mtep_pkg.sv]
package mtep_pkg;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF  = 3'd0,
    KIND_NOTE_ON   = 3'd1,
    KIND_CHANNEL   = 3'd2,
    KIND_TRACK_END = 3'd3,
    KIND_DONE      = 3'd4,
    KIND_BAD_HDR   = 3'd5,
    KIND_BAD_TRK   = 3'd6
  } kind_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] track_index;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [27:0] delta_time;
  } event_t;

  localparam logic [7:0] STATUS_MIN   = 8'h80;
  localparam logic [7:0] SYSTEM_MIN   = 8'hF0;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;
  localparam logic [7:0] META_STATUS  = 8'hFF;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;

  function automatic logic [7:0] hdr_tag(input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0: r = 8'h4D;
      2'd1: r = 8'h54;
      2'd2: r = 8'h68;
      default: r = 8'h64;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] trk_tag(input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0: r = 8'h4D;
      2'd1: r = 8'h54;
      2'd2: r = 8'h72;
      default: r = 8'h6B;
    endcase
    return r;
  endfunction

endpackage

[sv/mtep_byte_if.sv]
interface mtep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, data_byte, input ready);
  modport sink (input valid, data_byte, output ready);
endinterface

[sv/mtep_event_if.sv]
interface mtep_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [15:0] track_index;
  logic [3:0]  channel;
  logic [6:0]  note;
  logic [6:0]  velocity;
  logic [27:0] delta_time;
  modport source (output valid, event_kind, track_index, channel, note, velocity,
                  delta_time, input ready);
  modport sink (input valid, event_kind, track_index, channel, note, velocity,
                delta_time, output ready);
endinterface

[sv/midi_track_event_parser.sv]
// A byte's event passes through the parser register, then the queue, before it reaches the output.
// Throughput: one byte per cycle unless the input stalls; a 2-word queue decouples the parser from the output.
// Input stalls only when the queue is full and the parser holds an event.
// Reset (rst, synchronous, active high) returns to expecting the header identifier.
// Errors and done are sticky until reset.
module midi_track_event_parser (
  input logic          clk,
  input logic          rst,
  mtep_byte_if.sink    in_ch,
  mtep_event_if.source out_ch
);
  logic             pv, pr;
  mtep_pkg::event_t pw, qw;

  mtep_parser u_parser (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_byte(in_ch.data_byte),
    .ev_valid(pv), .ev_ready(pr), .ev(pw)
  );

  mtep_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(pv), .in_ready(pr), .in_word(pw),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(qw)
  );

  assign out_ch.event_kind  = qw.event_kind;
  assign out_ch.track_index = qw.track_index;
  assign out_ch.channel     = qw.channel;
  assign out_ch.note        = qw.note;
  assign out_ch.velocity    = qw.velocity;
  assign out_ch.delta_time  = qw.delta_time;
endmodule

[sv/mtep_parser.sv]
module mtep_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  output logic                ev_valid,
  input  logic                ev_ready,
  output mtep_pkg::event_t    ev
);
  typedef enum logic [16:0] {
    PH_HDR_ID    = 17'd1 << 0,
    PH_HDR_LEN   = 17'd1 << 1,
    PH_HDR_FMT   = 17'd1 << 2,
    PH_HDR_NTRK  = 17'd1 << 3,
    PH_HDR_DIV   = 17'd1 << 4,
    PH_TRK_ID    = 17'd1 << 5,
    PH_TRK_LEN   = 17'd1 << 6,
    PH_DELTA     = 17'd1 << 7,
    PH_STATUS    = 17'd1 << 8,
    PH_DATA1     = 17'd1 << 9,
    PH_DATA2     = 17'd1 << 10,
    PH_SYX_LEN   = 17'd1 << 11,
    PH_META_TYPE = 17'd1 << 12,
    PH_META_LEN  = 17'd1 << 13,
    PH_SKIP      = 17'd1 << 14,
    PH_DONE      = 17'd1 << 15,
    PH_ERROR     = 17'd1 << 16
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  running_status, running_status_next;
  logic [7:0]  event_status, event_status_next;
  logic [27:0] delta_accum, delta_accum_next;
  logic [6:0]  first_data, first_data_next;
  logic [27:0] skip_count, skip_count_next;
  logic [15:0] tracks_total, tracks_total_next;
  logic [15:0] track_number, track_number_next;
  logic [7:0]  meta_kind, meta_kind_next;
  logic        emit;
  mtep_pkg::event_t res;
  logic [27:0] skip_shift, skip_dec;
  logic [15:0] track_inc;
  logic        go;

  assign in_ready = !ev_valid || ev_ready;
  assign go = in_valid && in_ready;
  assign skip_shift = {skip_count[20:0], in_byte[6:0]};
  assign skip_dec = skip_count - 28'd1;
  assign track_inc = track_number + 16'd1;

  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    running_status_next = running_status;
    event_status_next = event_status;
    delta_accum_next = delta_accum;
    first_data_next = first_data;
    skip_count_next = skip_count;
    tracks_total_next = tracks_total;
    track_number_next = track_number;
    meta_kind_next = meta_kind;
    emit = 1'b0;
    res = '0;
    res.track_index = track_number;
    begin : body
      logic [7:0] st;
      logic [6:0] second;
      logic       chan_done;
      logic       body_end;
      st = event_status;
      second = '0;
      chan_done = 1'b0;
      body_end = 1'b0;
      unique case (phase)
        PH_HDR_ID: begin
          if (in_byte != mtep_pkg::hdr_tag(byte_count[1:0])) begin
            phase_next = PH_ERROR;
            emit = 1'b1;
            res.event_kind = mtep_pkg::KIND_BAD_HDR;
          end else if (byte_count == 3'd3) begin
            phase_next = PH_HDR_LEN;
            byte_count_next = '0;
          end else byte_count_next = byte_count + 3'd1;
        end
        PH_HDR_LEN: begin
          if (byte_count == 3'd3) begin
            phase_next = PH_HDR_FMT;
            byte_count_next = '0;
          end else byte_count_next = byte_count + 3'd1;
        end
        PH_HDR_FMT: begin
          if (byte_count == 3'd1) begin
            phase_next = PH_HDR_NTRK;
            byte_count_next = '0;
          end else byte_count_next = byte_count + 3'd1;
        end
        PH_HDR_NTRK: begin
          tracks_total_next = {tracks_total[7:0], in_byte};
          if (byte_count == 3'd1) begin
            phase_next = PH_HDR_DIV;
            byte_count_next = '0;
          end else byte_count_next = byte_count + 3'd1;
        end
        PH_HDR_DIV: begin
          if (byte_count == 3'd1) begin
            byte_count_next = '0;
            track_number_next = '0;
            if (tracks_total == '0) begin
              phase_next = PH_DONE;
              emit = 1'b1;
              res.event_kind = mtep_pkg::KIND_DONE;
              res.track_index = '0;
            end else phase_next = PH_TRK_ID;
          end else byte_count_next = byte_count + 3'd1;
        end
        PH_TRK_ID: begin
          if (in_byte != mtep_pkg::trk_tag(byte_count[1:0])) begin
            phase_next = PH_ERROR;
            emit = 1'b1;
            res.event_kind = mtep_pkg::KIND_BAD_TRK;
          end else if (byte_count == 3'd3) begin
            phase_next = PH_TRK_LEN;
            byte_count_next = '0;
          end else byte_count_next = byte_count + 3'd1;
        end
        PH_TRK_LEN: begin
          if (byte_count == 3'd3) begin
            byte_count_next = '0;
            running_status_next = '0;
            phase_next = PH_DELTA;
            delta_accum_next = '0;
          end else byte_count_next = byte_count + 3'd1;
        end
        PH_DELTA: begin
          delta_accum_next = {delta_accum[20:0], in_byte[6:0]};
          if (!in_byte[7]) phase_next = PH_STATUS;
        end
        PH_STATUS: begin
          if (in_byte < mtep_pkg::STATUS_MIN) begin
            if (running_status == '0) begin
              phase_next = PH_ERROR;
              emit = 1'b1;
              res.event_kind = mtep_pkg::KIND_BAD_TRK;
            end else begin
              st = running_status;
              event_status_next = running_status;
              first_data_next = in_byte[6:0];
              if (st[7:4] == mtep_pkg::HI_PROGRAM || st[7:4] == mtep_pkg::HI_PRESSURE)
                chan_done = 1'b1;
              else phase_next = PH_DATA2;
            end
          end else begin
            event_status_next = in_byte;
            if (in_byte < mtep_pkg::SYSTEM_MIN) begin
              running_status_next = in_byte;
              phase_next = PH_DATA1;
            end else if (in_byte == mtep_pkg::SYSEX_START ||
                         in_byte == mtep_pkg::SYSEX_ESCAPE) begin
              running_status_next = '0;
              skip_count_next = '0;
              phase_next = PH_SYX_LEN;
            end else if (in_byte == mtep_pkg::META_STATUS) begin
              running_status_next = '0;
              phase_next = PH_META_TYPE;
            end else begin
              phase_next = PH_DELTA;
              delta_accum_next = '0;
            end
          end
        end
        PH_DATA1: begin
          first_data_next = in_byte[6:0];
          if (st[7:4] == mtep_pkg::HI_PROGRAM || st[7:4] == mtep_pkg::HI_PRESSURE)
            chan_done = 1'b1;
          else phase_next = PH_DATA2;
        end
        PH_DATA2: begin
          second = in_byte[6:0];
          chan_done = 1'b1;
        end
        PH_META_TYPE: begin
          meta_kind_next = in_byte;
          skip_count_next = '0;
          phase_next = PH_META_LEN;
        end
        PH_SYX_LEN, PH_META_LEN: begin
          skip_count_next = skip_shift;
          if (!in_byte[7]) begin
            if (skip_shift == '0) body_end = 1'b1;
            else phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_count_next = skip_dec;
          if (skip_dec == '0) body_end = 1'b1;
        end
        PH_DONE, PH_ERROR: ;
        default: ;
      endcase
      if (chan_done) begin
        emit = 1'b1;
        phase_next = PH_DELTA;
        delta_accum_next = '0;
        res.channel = st[3:0];
        res.delta_time = delta_accum;
        if (st[7:4] == mtep_pkg::HI_NOTE_OFF) begin
          res.event_kind = mtep_pkg::KIND_NOTE_OFF;
          res.note = first_data_next;
          res.velocity = second;
        end else if (st[7:4] == mtep_pkg::HI_NOTE_ON) begin
          res.event_kind = (second == '0) ? mtep_pkg::KIND_NOTE_OFF
                                          : mtep_pkg::KIND_NOTE_ON;
          res.note = first_data_next;
          res.velocity = second;
        end else res.event_kind = mtep_pkg::KIND_CHANNEL;
      end
      if (body_end) begin
        if (event_status == mtep_pkg::META_STATUS && meta_kind == mtep_pkg::META_EOT) begin
          emit = 1'b1;
          res.delta_time = delta_accum;
          if (track_inc >= tracks_total) begin
            phase_next = PH_DONE;
            res.event_kind = mtep_pkg::KIND_DONE;
          end else begin
            res.event_kind = mtep_pkg::KIND_TRACK_END;
            track_number_next = track_inc;
            phase_next = PH_TRK_ID;
            byte_count_next = '0;
          end
        end else begin
          phase_next = PH_DELTA;
          delta_accum_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR_ID;
      byte_count <= '0;
      running_status <= '0;
      event_status <= '0;
      delta_accum <= '0;
      first_data <= '0;
      skip_count <= '0;
      tracks_total <= '0;
      track_number <= '0;
      meta_kind <= '0;
      ev_valid <= 1'b0;
    end else begin
      if (go) begin
        phase <= phase_next;
        byte_count <= byte_count_next;
        running_status <= running_status_next;
        event_status <= event_status_next;
        delta_accum <= delta_accum_next;
        first_data <= first_data_next;
        skip_count <= skip_count_next;
        tracks_total <= tracks_total_next;
        track_number <= track_number_next;
        meta_kind <= meta_kind_next;
        ev_valid <= emit;
      end else if (ev_ready) begin
        ev_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) ev <= res;
  end
endmodule

[sv/mtep_queue.sv]
module mtep_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mtep_pkg::event_t in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output mtep_pkg::event_t out_word
);
  mtep_pkg::event_t slot [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_word = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_word;
  end
endmodule

[sv/mtep_checker.sv]
module mtep_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_kind,
  input logic [6:0]  note,
  input logic [6:0]  velocity
);
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("event after reset");
  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");
  a_nonnote_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != mtep_pkg::KIND_NOTE_OFF &&
    event_kind != mtep_pkg::KIND_NOTE_ON |-> note == '0 && velocity == '0)
    else $error("note fields on non-note event");
  a_noteon_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == mtep_pkg::KIND_NOTE_ON |-> velocity != '0)
    else $error("note on with zero velocity");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind))
    else $error("output dropped");
endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk(clk), .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .event_kind(out_ch.event_kind), .note(out_ch.note), .velocity(out_ch.velocity)
);
